// ----- hw/rtl/spq_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and default sizes for the sorted priority queue.
package spq_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int KEY_BITS_DEF = 16;
    localparam int ID_BITS_DEF  = 8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_EMPTY = 2'd2
    } spq_status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic        capture;
        logic        apply;
        spq_status_t status;
    } spq_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic op_remove;
        logic full;
        logic empty;
    } spq_stat_t;

endpackage

// ----- hw/rtl/spq_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: sorted register array with per-entry insert and shift logic, and result registers.
module spq_datapath
    import spq_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF,
    parameter int ID_BITS  = ID_BITS_DEF,
    localparam int CNT_W   = $clog2(DEPTH + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  spq_cmd_t            cmd,
    output spq_stat_t           stat,
    input  logic                in_op,
    input  logic [KEY_BITS-1:0] in_key,
    input  logic [ID_BITS-1:0]  in_id,
    output logic [KEY_BITS-1:0] head_key,
    output logic [ID_BITS-1:0]  head_id,
    output logic                head_valid,
    output logic [CNT_W-1:0]    count,
    output spq_status_t         status
);

    logic                op_reg;
    logic [KEY_BITS-1:0] key_in_reg;
    logic [ID_BITS-1:0]  id_in_reg;

    logic [KEY_BITS-1:0] key_reg  [DEPTH];
    logic [KEY_BITS-1:0] key_next [DEPTH];
    logic [ID_BITS-1:0]  id_reg   [DEPTH];
    logic [ID_BITS-1:0]  id_next  [DEPTH];
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    logic [DEPTH-1:0]    ge;
    logic [DEPTH-1:0]    ge_prev;

    logic [KEY_BITS-1:0] head_key_reg;
    logic [ID_BITS-1:0]  head_id_reg;
    logic                head_valid_reg;
    logic [CNT_W-1:0]    count_out_reg;
    spq_status_t         status_reg;

    assign stat.op_remove = (op_reg == OP_REMOVE);
    assign stat.full      = (count_reg == CNT_W'(DEPTH));
    assign stat.empty     = (count_reg == '0);

    // Each entry compares itself with the new key; the array is sorted, so the
    // flags form a run of ones from the insertion point to the last valid entry.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            ge[i] = (CNT_W'(i) < count_reg) && (key_reg[i] >= key_in_reg);
        end
        ge_prev = {ge[DEPTH-2:0], 1'b0};
    end

    always_comb begin
        key_next   = key_reg;
        id_next    = id_reg;
        count_next = count_reg;
        if (cmd.status == STS_OK) begin
            if (op_reg == OP_INSERT) begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (ge_prev[i]) begin
                        key_next[i] = key_reg[(i == 0) ? 0 : i - 1];
                        id_next[i]  = id_reg[(i == 0) ? 0 : i - 1];
                    end else if (ge[i] || (CNT_W'(i) == count_reg)) begin
                        key_next[i] = key_in_reg;
                        id_next[i]  = id_in_reg;
                    end
                end
                count_next = count_reg + CNT_W'(1);
            end else begin
                for (int i = 0; i < DEPTH - 1; i++) begin
                    key_next[i] = key_reg[i + 1];
                    id_next[i]  = id_reg[i + 1];
                end
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg     <= in_op;
            key_in_reg <= in_key;
            id_in_reg  <= in_id;
        end
        if (cmd.apply) begin
            key_reg        <= key_next;
            id_reg         <= id_next;
            head_key_reg   <= (count_next != '0) ? key_next[0] : '0;
            head_id_reg    <= (count_next != '0) ? id_next[0] : '0;
            head_valid_reg <= (count_next != '0);
            count_out_reg  <= count_next;
            status_reg     <= cmd.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.apply) begin
            count_reg <= count_next;
        end
    end

    assign head_key   = head_key_reg;
    assign head_id    = head_id_reg;
    assign head_valid = head_valid_reg;
    assign count      = count_out_reg;
    assign status     = status_reg;

    a_head_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_W'(2)) |-> (key_reg[0] <= key_reg[1]))
        else $error("head entries out of order");

    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.apply && cmd.status == STS_OK && op_reg == OP_INSERT)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not advance the entry count");

endmodule

// ----- hw/rtl/spq_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: request handshakes, status decision and result valid flag.
module spq_ctrl
    import spq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  spq_stat_t stat,
    output spq_cmd_t  cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        cmd.capture = s_tvalid && s_tready;
        cmd.apply   = (state_reg == ST_EXEC) && out_free;
        if (!stat.op_remove && stat.full) begin
            cmd.status = STS_FULL;
        end else if (stat.op_remove && stat.empty) begin
            cmd.status = STS_EMPTY;
        end else begin
            cmd.status = STS_OK;
        end
    end

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (cmd.capture) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // The update waits until the result register can take the new result.
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_EXEC))
        else $error("accepted request not executed next");

    a_apply_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.apply |=> m_tvalid)
        else $error("update produced no result");

endmodule

// ----- hw/rtl/sorted_priority_queue.sv -----
`timescale 1ns / 1ps
// Top level of the sorted priority queue: port packing, controller and datapath.
// An accepted request is captured into the input registers, and the update then writes
// its result to m_tdata when the result register is free; a held result delays the
// update until it is taken. A new request is accepted only after that update, once the
// controller is idle; all entries compare and shift in parallel in the update cycle.
// Reset (aresetn low, synchronous) empties the queue, clears the result valid flag and
// returns the controller to idle.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF,
    parameter int ID_BITS  = ID_BITS_DEF,
    localparam int CNT_W   = $clog2(DEPTH + 1),
    localparam int S_W     = ((KEY_BITS + ID_BITS + 7) / 8) * 8,
    localparam int M_W     = ((KEY_BITS + ID_BITS + 1 + CNT_W + 2 + 7) / 8) * 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [S_W-1:0] s_tdata,  // item_key, item_id
    input  logic [0:0]     s_tuser,  // op
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [M_W-1:0] m_tdata   // head_key, head_id, head_valid, count, status
);

    spq_cmd_t            cmd;
    spq_stat_t           stat;
    logic [KEY_BITS-1:0] head_key;
    logic [ID_BITS-1:0]  head_id;
    logic                head_valid;
    logic [CNT_W-1:0]    count;
    spq_status_t         status;

    spq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    spq_datapath #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS),
        .ID_BITS  (ID_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_op      (s_tuser[0]),
        .in_key     (s_tdata[KEY_BITS-1:0]),
        .in_id      (s_tdata[KEY_BITS +: ID_BITS]),
        .head_key   (head_key),
        .head_id    (head_id),
        .head_valid (head_valid),
        .count      (count),
        .status     (status)
    );

    assign m_tdata = M_W'({status, count, head_valid, head_id, head_key});

endmodule
